FILE: rtl/srsc_pkg.sv
// package with constants, codes and types of the shadow return stack checker
package srsc_pkg;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned PtrW       = $clog2(StackDepth + 1);
  localparam int unsigned IdxW       = $clog2(StackDepth);
  localparam int unsigned AddrW      = 64;
  localparam int unsigned DepthW     = 11;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 80;

  typedef enum logic [1:0] {
    CMD_CALL   = 2'd0,
    CMD_RETURN = 2'd1,
    CMD_SIGNAL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_MISMATCH = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FSM_RUN    = 1'b0,
    FSM_REFILL = 1'b1
  } fsm_e;

  typedef struct packed {
    logic             wild;
    logic [AddrW-1:0] addr;
  } entry_t;

endpackage

FILE: rtl/shadow_return_stack_checker.sv
// top level of the shadow return stack checker
//
// shadow return-address stack: a call beat pushes its return address, a signal beat pushes a
// wildcard entry (address zero, tag set), a clear beat empties the stack and a return beat
// checks its target against the top entry. a matching or wildcard top is popped; otherwise the
// beat reports an empty stack, or a mismatch together with the top address, and the stack stays
// as it was. a push onto a full stack reports overflow and is dropped. each input beat gives
// exactly one result beat carrying the status and the depth after the beat. the top entry is
// cached in a register and the entries below it live in a single-port synchronous ram with a
// registered read. calls, signals, clears and returns that fail or leave the stack empty need
// no refill; a return that pops with entries still below stalls input in the refill state
// while the ram fetches the new top for the next beat to look at. there is no clearing pass
// after reset: entries are only ever read below the stack pointer, which reset sets to zero.
module shadow_return_stack_checker
  import srsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [63:0] address
  input  logic [1:0]          s_axis_tuser,   // [1:0] command
  // result beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [1:0] status, [2] wildcard_taken,
                                              // [66:3] top_address, [77:67] stack_depth,
                                              // [79:78] zero
);

  // control state
  fsm_e            state_q, state_d;
  logic [PtrW-1:0] sp_q, sp_d;
  logic            out_valid_q, out_valid_d;

  // cached top entry (index sp_q - 1 when the stack is not empty)
  entry_t          top_q, top_d;

  // result payload
  status_e          res_status_q, res_status_d;
  logic             res_wild_q, res_wild_d;
  logic [AddrW-1:0] res_top_q, res_top_d;
  logic [DepthW-1:0] res_depth_q, res_depth_d;

  // entries below the top
  entry_t            mem_q [StackDepth];
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata_q;

  logic            in_fire;
  cmd_e            cmd;
  logic [AddrW-1:0] addr;
  logic [PtrW-1:0] sp_dec1, sp_dec2;

  assign cmd     = cmd_e'(s_axis_tuser);
  assign addr    = s_axis_tdata[AddrW-1:0];
  assign sp_dec1 = sp_q - PtrW'(1);
  assign sp_dec2 = sp_q - PtrW'(2);

  // a new beat only when the top is settled and the result slot is free
  assign s_axis_tready = (state_q == FSM_RUN) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_RUN;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    res_status_q <= res_status_d;
    res_wild_q   <= res_wild_d;
    res_top_q    <= res_top_d;
    res_depth_q  <= res_depth_d;
  end

  // next state, stack update and result
  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    top_d        = top_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    res_status_d = res_status_q;
    res_wild_d   = res_wild_q;
    res_top_d    = res_top_q;
    res_depth_d  = res_depth_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = sp_dec1[IdxW-1:0];
    mem_raddr    = sp_dec2[IdxW-1:0];
    mem_wdata    = top_q;

    unique case (state_q)
      FSM_REFILL: begin
        // new top arrives from the ram
        top_d   = mem_rdata_q;
        state_d = FSM_RUN;
      end
      FSM_RUN: begin
        if (in_fire) begin
          out_valid_d  = 1'b1;
          res_status_d = STS_OK;
          res_wild_d   = 1'b0;
          res_top_d    = '0;
          unique case (cmd)
            CMD_CALL, CMD_SIGNAL: begin
              if (sp_q == PtrW'(StackDepth)) begin
                res_status_d = STS_OVERFLOW;
              end else begin
                // spill the old top below, new entry goes to the cache
                mem_we     = (sp_q != '0);
                top_d.wild = (cmd == CMD_SIGNAL);
                top_d.addr = (cmd == CMD_SIGNAL) ? '0 : addr;
                sp_d       = sp_q + PtrW'(1);
              end
            end
            CMD_CLEAR: begin
              sp_d = '0;
            end
            CMD_RETURN: begin
              if (sp_q == '0) begin
                res_status_d = STS_EMPTY;
              end else begin
                res_top_d = top_q.addr;
                if (top_q.wild || (top_q.addr == addr)) begin
                  res_wild_d = top_q.wild;
                  sp_d       = sp_dec1;
                  if (sp_dec1 != '0) begin
                    mem_re  = 1'b1;
                    state_d = FSM_REFILL;
                  end
                end else begin
                  res_status_d = STS_MISMATCH;
                end
              end
            end
            default: ;
          endcase
          res_depth_d = DepthW'(sp_d);
        end
      end
      default: state_d = FSM_RUN;
    endcase
  end

  // single-port ram: push writes and pop reads never meet in one cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_depth_q, res_top_q, res_wild_q, res_status_q};

endmodule
